// File: sv/mws_pkg.sv
// Package: widths, defaults and sequencer states for the moving window statistics block.
package mws_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int SUM_W            = 20;
    localparam int FILL_W           = 5;
    localparam int WINDOW_SIZE_DEF  = 16;
    localparam int TRIM_MIN_COUNT   = 3;
    localparam int TRIM_DROP        = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_SCAN,
        ST_MEAN,
        ST_TRIM,
        ST_OUT
    } mws_state_t;

endpackage

// File: sv/moving_window_statistics.sv
// Top level: ring store of samples with running sum, min/max scan and serial means.
//
//  channel | signals                                   | dir | accepted when
//  --------+-------------------------------------------+-----+----------------------
//  input   | sample, clear                             | in  | in_valid & in_ready
//  result  | window_sum, fill_count, mean,             | out | out_valid & out_ready
//          | trimmed_mean, lowest, highest             |     |
//
// A clear word goes straight to the result. A sample word takes one store read
// for the overwritten entry, one store read per filled entry for min/max, and
// one pass of the one-bit-per-cycle divider, or two once three entries are filled
// (DVD_W = 22 at a window of 16).
// After reset the store needs no clearing: only entries below the fill count are used.
// in_ready is high only between words; a finished result waits in the output
// register, and the next word stalls at its end until that result is taken.
module moving_window_statistics #(
    parameter int WINDOW_SIZE = mws_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 clear,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mws_pkg::SUM_W-1:0]     window_sum,
    output logic        [mws_pkg::FILL_W-1:0]    fill_count,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  mean,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  trimmed_mean,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  lowest,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  highest
);
    import mws_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int TOT_W = SAMPLE_W + CNT_W;
    localparam int DVD_W = TOT_W + 1;

    mws_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]           slot_reg,  slot_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [TOT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]           scan_reg,  scan_next;
    logic                       pend_reg,  pend_next;
    logic signed [SAMPLE_W-1:0] samp_reg,  samp_next;
    logic signed [SAMPLE_W-1:0] lo_reg,    lo_next;
    logic signed [SAMPLE_W-1:0] hi_reg,    hi_next;
    logic signed [SAMPLE_W-1:0] mean_reg,  mean_next;
    logic signed [SAMPLE_W-1:0] trim_reg,  trim_next;
    logic                       oval_reg,  oval_next;
    logic                       load_out;

    logic signed [SUM_W-1:0]    osum_reg;
    logic [FILL_W-1:0]          ocnt_reg;
    logic signed [SAMPLE_W-1:0] omean_reg, otrim_reg, olo_reg, ohi_reg;

    // sample store
    logic signed [SAMPLE_W-1:0] store_mem [WINDOW_SIZE];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;

    logic                       full;
    logic signed [SAMPLE_W-1:0] old_val;

    logic                       div_start;
    logic signed [DVD_W-1:0]    div_dividend;
    logic [CNT_W-1:0]           div_divisor;
    logic                       div_done;
    logic signed [DVD_W-1:0]    div_quotient;

    mws_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign full    = (count_reg == CNT_W'(WINDOW_SIZE));
    assign old_val = full ? rd_data_reg : '0;

    // store ports: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[slot_reg] <= samp_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        scan_next    = scan_reg;
        pend_next    = 1'b0;
        samp_next    = samp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mean_next    = mean_reg;
        trim_next    = trim_reg;
        oval_next    = oval_reg;
        load_out     = 1'b0;
        in_ready     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = slot_reg;
        wr_en        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DVD_W'(total_reg);
        div_divisor  = count_reg;

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (clear)
                    begin
                        slot_next  = '0;
                        count_next = '0;
                        total_next = '0;
                        lo_next    = '0;
                        hi_next    = '0;
                        mean_next  = '0;
                        trim_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        samp_next  = sample;
                        rd_en      = 1'b1;
                        state_next = ST_OLD;
                    end
                end
            end

            // overwritten entry is in; update sum, ring pointer and fill count
            ST_OLD:
            begin
                wr_en      = 1'b1;
                total_next = total_reg - TOT_W'(old_val) + TOT_W'(samp_reg);
                slot_next  = (slot_reg == IDX_W'(WINDOW_SIZE - 1)) ? '0 : slot_reg + 1'b1;
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                end
                scan_next  = '0;
                state_next = ST_SCAN;
            end

            // walk entries 0 .. count-1, one read a cycle
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (scan_reg == CNT_W'(1))
                    begin
                        lo_next = rd_data_reg;
                        hi_next = rd_data_reg;
                    end
                    else
                    begin
                        if (rd_data_reg < lo_reg)
                        begin
                            lo_next = rd_data_reg;
                        end
                        if (rd_data_reg > hi_reg)
                        begin
                            hi_next = rd_data_reg;
                        end
                    end
                end
                if (scan_reg != count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_MEAN;
                end
            end

            ST_MEAN:
            begin
                div_dividend = DVD_W'(total_reg) - DVD_W'(lo_reg) - DVD_W'(hi_reg);
                div_divisor  = count_reg - CNT_W'(TRIM_DROP);
                if (div_done)
                begin
                    mean_next = SAMPLE_W'(div_quotient);
                    if (count_reg >= CNT_W'(TRIM_MIN_COUNT))
                    begin
                        div_start  = 1'b1;
                        state_next = ST_TRIM;
                    end
                    else
                    begin
                        trim_next  = '0;
                        state_next = ST_OUT;
                    end
                end
            end

            ST_TRIM:
            begin
                if (div_done)
                begin
                    trim_next  = SAMPLE_W'(div_quotient);
                    state_next = ST_OUT;
                end
            end

            // hand over once the output register is free
            ST_OUT:
            begin
                if (!oval_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
            total_reg <= total_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
        end
    end

    // working and output words
    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mean_reg <= mean_next;
        trim_reg <= trim_next;
        if (load_out)
        begin
            osum_reg  <= SUM_W'(total_reg);
            ocnt_reg  <= FILL_W'(count_reg);
            omean_reg <= mean_reg;
            otrim_reg <= trim_reg;
            olo_reg   <= lo_reg;
            ohi_reg   <= hi_reg;
        end
    end

    assign out_valid    = oval_reg;
    assign window_sum   = osum_reg;
    assign fill_count   = ocnt_reg;
    assign mean         = omean_reg;
    assign trimmed_mean = otrim_reg;
    assign lowest       = olo_reg;
    assign highest      = ohi_reg;

endmodule

// File: sv/mws_div.sv
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
module mws_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic        [DVS_W-1:0] divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);
    import mws_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              neg_reg,   neg_next;
    logic [DVD_W-1:0]  quo_reg,   quo_next;
    logic [DVS_W-1:0]  rem_reg,   rem_next;
    logic [DVS_W-1:0]  dvs_reg,   dvs_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;

    // one restoring step per cycle on the magnitudes
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[DVD_W-1];
            quo_next  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// File: tb/mws_checker.sv
// Checker for moving_window_statistics: predicts each result and compares it on acceptance.
`timescale 1ns / 100ps

module mws_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 clear,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [mws_pkg::SUM_W-1:0]     window_sum,
    input  logic        [mws_pkg::FILL_W-1:0]    fill_count,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  mean,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  trimmed_mean,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  lowest,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  highest,
    output int                                   mismatches,
    output int                                   outstanding
);
    import mws_pkg::*;

    localparam int WIN = WINDOW_SIZE_DEF;

    typedef struct {
        logic signed [SUM_W-1:0]    window_sum;
        logic        [FILL_W-1:0]   fill_count;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] trimmed_mean;
        logic signed [SAMPLE_W-1:0] lowest;
        logic signed [SAMPLE_W-1:0] highest;
    } window_stats_t;

    // model copy of the ring and its counters
    logic signed [SAMPLE_W-1:0] ring [WIN];
    int                         slot;
    int                         filled;
    longint                     total;

    window_stats_t              stats_q[$];

    initial mismatches = 0;

    // empty the model window
    function automatic void empty_window();
        int k;
        for (k = 0; k < WIN; k++)
            ring[k] = '0;
        slot   = 0;
        filled = 0;
        total  = 0;
    endfunction

    // absorb one word into the model and return the statistics it yields
    function automatic window_stats_t stats_after_word(
        input logic signed [SAMPLE_W-1:0] value,
        input logic                       clr
    );
        window_stats_t r;
        longint        lo;
        longint        hi;
        longint        avg;
        longint        trim;
        int            k;
        if (clr)
            empty_window();
        else
        begin
            total      = total - ring[slot] + value;
            ring[slot] = value;
            slot       = (slot == WIN - 1) ? 0 : slot + 1;
            if (filled < WIN)
                filled++;
        end
        lo   = 0;
        hi   = 0;
        avg  = 0;
        trim = 0;
        // ring fills from slot 0 upward, so the filled part is 0 .. filled-1
        if (filled > 0)
        begin
            lo = ring[0];
            hi = ring[0];
            for (k = 1; k < filled; k++)
            begin
                if (ring[k] < lo) lo = ring[k];
                if (ring[k] > hi) hi = ring[k];
            end
            avg = total / filled;
        end
        if (filled >= TRIM_MIN_COUNT)
            trim = (total - lo - hi) / (filled - TRIM_DROP);
        r.window_sum   = total[SUM_W-1:0];
        r.fill_count   = filled[FILL_W-1:0];
        r.mean         = avg[SAMPLE_W-1:0];
        r.trimmed_mean = trim[SAMPLE_W-1:0];
        r.lowest       = lo[SAMPLE_W-1:0];
        r.highest      = hi[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // predict on input words, compare on result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_window();
            stats_q.delete();
            outstanding <= 0;
        end
        else
        begin
            window_stats_t want;
            if (in_valid && in_ready)
                stats_q.push_back(stats_after_word(sample, clear));
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, actual sum %0d count %0d",
                             $time, window_sum, fill_count);
                    mismatches++;
                end
                else
                begin
                    want = stats_q.pop_front();
                    compare_field("window_sum",   want.window_sum,   window_sum);
                    compare_field("fill_count",   want.fill_count,   fill_count);
                    compare_field("mean",         want.mean,         mean);
                    compare_field("trimmed_mean", want.trimmed_mean, trimmed_mean);
                    compare_field("lowest",       want.lowest,       lowest);
                    compare_field("highest",      want.highest,      highest);
                end
            end
            outstanding <= stats_q.size();
        end
    end

endmodule

// File: tb/tb_moving_window_statistics.sv
// Testbench top for moving_window_statistics: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_moving_window_statistics;
    import mws_pkg::*;

    localparam int RANDOM_WORDS = 1230;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 9;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        clear        = 1'b0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [SUM_W-1:0]     window_sum;
    logic        [FILL_W-1:0]    fill_count;
    logic signed [SAMPLE_W-1:0]  mean;
    logic signed [SAMPLE_W-1:0]  trimmed_mean;
    logic signed [SAMPLE_W-1:0]  lowest;
    logic signed [SAMPLE_W-1:0]  highest;

    int                          mismatches;
    int                          outstanding;
    int                          cycles       = 0;
    logic                        idle_on      = 1'b1;

    moving_window_statistics i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .clear        (clear),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_sum   (window_sum),
        .fill_count   (fill_count),
        .mean         (mean),
        .trimmed_mean (trimmed_mean),
        .lowest       (lowest),
        .highest      (highest)
    );

    mws_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .clear        (clear),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_sum   (window_sum),
        .fill_count   (fill_count),
        .mean         (mean),
        .trimmed_mean (trimmed_mean),
        .lowest       (lowest),
        .highest      (highest),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("moving_window_statistics regression: fail");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        out_ready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));

    // offer one word and hold it until taken
    task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic clr);
        while (idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        clear    <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // random sample drawn according to the current stretch's flavour
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int flavour);
        logic signed [SAMPLE_W-1:0] v;
        case (flavour)
            4:       case ($urandom_range(3))
                         0: v = S_MAX;
                         1: v = S_MIN;
                         2: v = '0;
                         default: v = -16'sd1;
                     endcase
            6:       v = $signed(16'($urandom_range(15))) - 16'sd8;
            7:       v = $urandom_range(1) ? S_MAX - 16'($urandom_range(7))
                                           : S_MIN + 16'($urandom_range(7));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        int                         sent;
        int                         flavour;
        int                         run;
        logic signed [SAMPLE_W-1:0] held;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear on empty, growth through 1, 2, 3 entries, extremes
        send_word(16'sh1234, 1'b1);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd1, 1'b0);
        send_word(16'sh5555, 1'b0);
        send_word(16'shAAAA, 1'b0);
        send_word(-16'sd7, 1'b0);
        send_word(16'sd7, 1'b0);
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b1);
        send_word(-16'sd5, 1'b0);
        send_word(16'sd3, 1'b0);
        send_word(16'sd0, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(16'sd0, 1'b1);

        // random: stretches of one flavour, a few clears sprinkled in
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            // quiet stretch with no idling on either side
            idle_on <= !(sent >= 400 && sent < 700);
            flavour  = $urandom_range(9);
            run      = (flavour == 5) ? $urandom_range(16, 40) : $urandom_range(1, 40);
            held     = $urandom_range(1) ? ($urandom_range(1) ? S_MAX : S_MIN)
                                         : 16'($urandom);
            repeat (run)
            begin
                if ($urandom_range(99) < 3)
                    send_word(16'($urandom), 1'b1);
                else if (flavour == 5)
                    send_word(held, 1'b0);
                else
                    send_word(pick_sample(flavour), 1'b0);
                sent++;
            end
        end
        in_valid <= 1'b0;
        idle_on  <= 1'b1;

        // drain; first let the checker count the last word
        @(posedge clk);
        while (outstanding != 0 || out_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("moving_window_statistics regression: pass");
        else
            $display("moving_window_statistics regression: fail");
        $finish;
    end

endmodule
